### rtl/core/modular_arithmetic_unit_assert.svh
// Assertion macros for the modular arithmetic unit.
// Used by the top level only; needs no other file.
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH

// Implication checked on every edge outside reset.
`define MAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mau_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the modular arithmetic unit.
// No dependencies.
package mau_pkg;
  localparam int unsigned DefaultWidth = 32;

  localparam logic [2:0] KindAdd    = 3'd0;
  localparam logic [2:0] KindSub    = 3'd1;
  localparam logic [2:0] KindMul    = 3'd2;
  localparam logic [2:0] KindInv    = 3'd3;
  localparam logic [2:0] KindDiv    = 3'd4;
  localparam logic [2:0] KindSol    = 3'd5;
  localparam logic [2:0] KindAll    = 3'd6;
  localparam logic [2:0] KindUnused = 3'd7;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusNoInv = 2'd1;
  localparam logic [1:0] StatusNoSol = 2'd2;

  // Byte address of the modulus register.
  localparam logic [1:0] AddrModulus = 2'd0;

  // Operation codes for the serial engine.
  localparam logic [1:0] OpMul = 2'd0;
  localparam logic [1:0] OpDiv = 2'd1;
  localparam logic [1:0] OpRed = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } eng_ctl_t;

  typedef struct packed {
    logic done;
    logic busy;
  } eng_sts_t;
endpackage

### rtl/core/modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// Modular arithmetic unit: add, sub, multiply, inverse, divide, congruences.
// Add and sub reduce both operands in serial passes and then add or subtract;
// multiply adds a serial multiply pass. Euclid kinds use one serial pass
// to reduce a, two per Euclid step, and up to four final passes.
// One item at a time: the next item is accepted the cycle after the result is taken.
// Reset: modulus returns to 1, sequencer idle, no result pending.
module modular_arithmetic_unit #(
  parameter int unsigned Width = mau_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       kind_i,
  input  logic [Width-1:0] operand_a_i,
  input  logic [Width-1:0] operand_b_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [Width-1:0] value_o,
  output logic [Width-1:0] spacing_o,
  output logic [Width-1:0] solution_count_o,
  output logic [1:0]       status_o
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRedA  = 4'd1;
  localparam logic [3:0] StRedB  = 4'd2;
  localparam logic [3:0] StArith = 4'd3;
  localparam logic [3:0] StEDiv  = 4'd4;
  localparam logic [3:0] StEMul  = 4'd5;
  localparam logic [3:0] StFDiv  = 4'd6;
  localparam logic [3:0] StFRed  = 4'd7;
  localparam logic [3:0] StFMul  = 4'd8;
  localparam logic [3:0] StSpace = 4'd9;
  localparam logic [3:0] StOut   = 4'd10;
  localparam int unsigned MW = (Width < 32) ? Width : 32;

  logic [31:0]      mod_q;
  logic [Width-1:0] n_eff;
  logic [3:0]       st_q, st_d;
  logic [2:0]       kind_q, kind_d;
  logic [Width-1:0] a_q, a_d, b_q, b_d;
  logic [Width-1:0] r0_q, r0_d, r1_q, r1_d, s0_q, s0_d, s1_q, s1_d;
  logic [Width-1:0] val_q, val_d, spc_q, spc_d, cnt_q, cnt_d;
  logic [1:0]       sts_q, sts_d;
  logic             ov_q, ov_d;
  mau_pkg::eng_ctl_t ctl;
  mau_pkg::eng_sts_t est;
  logic [Width-1:0] ex, ey, en, equo, erem;
  logic             wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && (paddr == mau_pkg::AddrModulus);
  assign prdata = mod_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mod_q <= 32'd1;
    else if (wr) mod_q <= pwdata;
  end

  logic [Width-1:0] mod_w;
  assign mod_w = Width'(mod_q[MW-1:0]);
  assign n_eff = (mod_w == '0) ? Width'(1) : mod_w;

  mau_serial_engine #(.Width(Width)) u_eng (
    .clk_i, .rst_ni, .ctl_i(ctl), .x_i(ex), .y_i(ey), .n_i(en),
    .sts_o(est), .quo_o(equo), .rem_o(erem)
  );

  // Sum/difference of reduced operands, modulo n.
  logic [Width:0] sum, dif;
  always_comb begin
    sum = {1'b0, a_q} + {1'b0, b_q};
    if (sum >= {1'b0, n_eff}) sum = sum - {1'b0, n_eff};
    dif = (a_q >= b_q) ? {1'b0, a_q - b_q} : {1'b0, a_q} + {1'b0, n_eff - b_q};
  end

  assign in_stall_o = (st_q != StIdle);

  always_comb begin
    st_d = st_q; kind_d = kind_q; a_d = a_q; b_d = b_q;
    r0_d = r0_q; r1_d = r1_q; s0_d = s0_q; s1_d = s1_q;
    val_d = val_q; spc_d = spc_q; cnt_d = cnt_q; sts_d = sts_q; ov_d = ov_q;
    ctl = '0; ex = a_q; ey = b_q; en = n_eff;
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          kind_d = kind_i; a_d = operand_a_i; b_d = operand_b_i;
          val_d = '0; spc_d = '0; cnt_d = '0; sts_d = mau_pkg::StatusOk;
          if (kind_i == mau_pkg::KindUnused) begin
            st_d = StOut; ov_d = 1'b1;
          end else begin
            st_d = StRedA; ctl.start = 1'b1; ctl.op = mau_pkg::OpRed;
            ey = operand_a_i;
          end
        end
      end
      StRedA: if (est.done) begin
        a_d = erem;
        if (kind_q == mau_pkg::KindAdd || kind_q == mau_pkg::KindSub
            || kind_q == mau_pkg::KindMul) begin
          st_d = StRedB; ctl.start = 1'b1; ctl.op = mau_pkg::OpRed; ey = b_q;
        end else begin
          r0_d = erem; r1_d = n_eff;
          s0_d = (n_eff == Width'(1)) ? '0 : Width'(1); s1_d = '0;
          st_d = StEDiv;
          if (n_eff != '0) begin
            ctl.start = 1'b1; ctl.op = mau_pkg::OpDiv; ey = erem; en = n_eff;
          end
        end
      end
      StRedB: if (est.done) begin
        b_d = erem;
        if (kind_q == mau_pkg::KindMul) begin
          st_d = StArith; ctl.start = 1'b1; ctl.op = mau_pkg::OpMul;
          ex = a_q; ey = erem;
        end else begin
          st_d = StArith;
        end
      end
      StArith: begin
        if (kind_q == mau_pkg::KindMul) begin
          if (est.done) begin
            val_d = erem; st_d = StOut; ov_d = 1'b1;
          end
        end else begin
          val_d = (kind_q == mau_pkg::KindAdd) ? sum[Width-1:0] : dif[Width-1:0];
          st_d = StOut; ov_d = 1'b1;
        end
      end
      StEDiv: if (est.done) begin
        // Quotient r0/r1; next multiply q*s1 mod n.
        r0_d = r1_q; r1_d = erem;
        st_d = StEMul; ctl.start = 1'b1; ctl.op = mau_pkg::OpMul;
        ex = s1_q; ey = equo;
      end
      StEMul: if (est.done) begin
        s0_d = s1_q;
        s1_d = (s0_q >= erem) ? s0_q - erem : s0_q + (n_eff - erem);
        if (r1_q == '0) begin
          // r0_q holds g; s1_q holds s.
          if (kind_q == mau_pkg::KindInv || kind_q == mau_pkg::KindDiv) begin
            if (r0_q != Width'(1)) begin
              sts_d = mau_pkg::StatusNoInv; st_d = StOut; ov_d = 1'b1;
            end else if (kind_q == mau_pkg::KindInv) begin
              val_d = s1_q; st_d = StOut; ov_d = 1'b1;
            end else begin
              st_d = StFRed; ctl.start = 1'b1; ctl.op = mau_pkg::OpRed; ey = b_q;
            end
          end else begin
            st_d = StFDiv; ctl.start = 1'b1; ctl.op = mau_pkg::OpDiv;
            ey = b_q; en = r0_q;
          end
        end else begin
          st_d = StEDiv; ctl.start = 1'b1; ctl.op = mau_pkg::OpDiv;
          ey = r0_q; en = r1_q;
        end
      end
      StFDiv: if (est.done) begin
        // b/g in equo; s still in s0_q now.
        if (erem != '0) begin
          sts_d = mau_pkg::StatusNoSol; st_d = StOut; ov_d = 1'b1;
        end else begin
          cnt_d = r0_q;
          st_d = StFRed; ctl.start = 1'b1; ctl.op = mau_pkg::OpRed; ey = equo;
        end
      end
      StFRed: if (est.done) begin
        st_d = StFMul; ctl.start = 1'b1; ctl.op = mau_pkg::OpMul;
        ex = s0_q; ey = erem;
      end
      StFMul: if (est.done) begin
        val_d = erem;
        if (kind_q == mau_pkg::KindAll) begin
          st_d = StSpace; ctl.start = 1'b1; ctl.op = mau_pkg::OpDiv;
          ey = n_eff; en = r0_q;
        end else begin
          cnt_d = '0; st_d = StOut; ov_d = 1'b1;
        end
      end
      StSpace: if (est.done) begin
        spc_d = equo; st_d = StOut; ov_d = 1'b1;
      end
      StOut: if (!out_stall_i) begin
        ov_d = 1'b0; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; a_q <= a_d; b_q <= b_d;
    r0_q <= r0_d; r1_q <= r1_d; s0_q <= s0_d; s1_q <= s1_d;
    val_q <= val_d; spc_q <= spc_d; cnt_q <= cnt_d; sts_q <= sts_d;
  end

  assign out_valid_o      = ov_q;
  assign value_o          = val_q;
  assign spacing_o        = spc_q;
  assign solution_count_o = cnt_q;
  assign status_o         = sts_q;

`include "modular_arithmetic_unit_assert.svh"
  `MAU_ASSERT_IMP(a_out_state, out_valid_o, st_q == StOut, "result outside output state")
  `MAU_ASSERT_IMP(a_idle_ready, !out_valid_o && st_q == StIdle, !in_stall_o, "idle but stalled")
  `MAU_ASSERT_IMP(a_err_zero, out_valid_o && status_o != mau_pkg::StatusOk,
                  value_o == '0 && spacing_o == '0, "error result not zero")
  `MAU_ASSERT_NEXT(a_start_busy, ctl.start, est.busy, "engine did not start")
endmodule

### rtl/core/mau_serial_engine.sv
`timescale 1ns / 1ps
// Bit-serial engine: modular multiply, unsigned divide, or modular reduce.
// Depends on mau_pkg. One bit of the second operand (or quotient) per cycle.
module mau_serial_engine #(
  parameter int unsigned Width = mau_pkg::DefaultWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mau_pkg::eng_ctl_t ctl_i,
  input  logic [Width-1:0]  x_i,
  input  logic [Width-1:0]  y_i,
  input  logic [Width-1:0]  n_i,
  output mau_pkg::eng_sts_t sts_o,
  output logic [Width-1:0]  quo_o,
  output logic [Width-1:0]  rem_o
);
  localparam int unsigned CntW = $clog2(Width + 1);

  logic             busy_q, busy_d, done_q, done_d;
  logic [1:0]       op_q, op_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] acc_q, acc_d, sh_q, sh_d, x_q, x_d, n_q, n_d;

  // Doubling and adding modulo n with one extra bit; values stay below n.
  logic [Width:0] dbl, dbl_r, add, add_r, div_t;
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
    add   = dbl_r + {1'b0, x_q};
    add_r = (add >= {1'b0, n_q}) ? add - {1'b0, n_q} : add;
    div_t = {acc_q, sh_q[Width-1]};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    x_d    = x_q;
    n_d    = n_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      op_d   = ctl_i.op;
      cnt_d  = CntW'(Width);
      acc_d  = '0;
      sh_d   = y_i;
      x_d    = x_i;
      n_d    = n_i;
    end else if (busy_q) begin
      case (op_q)
        mau_pkg::OpMul: begin
          acc_d = sh_q[Width-1] ? add_r[Width-1:0] : dbl_r[Width-1:0];
          sh_d  = {sh_q[Width-2:0], 1'b0};
        end
        default: begin
          // Restoring division of sh by n; reduce keeps only the remainder.
          if (div_t >= {1'b0, n_q}) begin
            acc_d = Width'(div_t - {1'b0, n_q});
            sh_d  = {sh_q[Width-2:0], 1'b1};
          end else begin
            acc_d = div_t[Width-1:0];
            sh_d  = {sh_q[Width-2:0], 1'b0};
          end
        end
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= mau_pkg::OpMul;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    x_q   <= x_d;
    n_q   <= n_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.busy = busy_q;
  assign quo_o = sh_q;
  assign rem_o = acc_q;
endmodule
